>>> rtl/fifo_queue_with_remove_by_value_assert.svh
// Assertion macros for the FIFO queue with remove-by-value.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define FQRV_ASSERT_ALWAYS(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fqrv: invariant violated");

// Antecedent this cycle implies consequent in the next cycle.
`define FQRV_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fqrv: next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define FQRV_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fqrv: same-cycle check failed");

`endif

>>> rtl/fqrv_pkg.sv
// Package for the FIFO queue with remove-by-value: word types, operation
// and status codes, and the control word broadcast to the cells.
`timescale 1ns / 1ps
package fqrv_pkg;

	typedef enum logic [2:0] {
		OP_ENQ    = 3'd0,
		OP_DEQ    = 3'd1,
		OP_REMOVE = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_PEEK   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic signed [31:0] front_value;
		logic signed [31:0] rear_value;
		logic [4:0]         occupancy;
		logic               is_empty;
	} rsp_t;

	// Control word seen by every cell in the row
	typedef struct packed {
		logic        enq;
		logic        deq;
		logic        rem;
		logic [31:0] value;
	} cell_ctl_t;

endpackage

>>> rtl/fqrv_cell.sv
// One storage cell of the queue row: holds one entry, matches it against
// the broadcast word and takes its right neighbour's entry on a close-up.
// Depends on fqrv_pkg.
`timescale 1ns / 1ps
module fqrv_cell
	import fqrv_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  logic [CW-1:0]   count,
	input  logic [31:0]     right_value,
	input  logic            hit_in,
	output logic            hit_out,
	output logic [31:0]     value,
	output logic [31:0]     rear_tap
);

	logic [31:0] value_q;
	logic        occ;
	logic        last;
	logic        match;

	assign occ     = count > CW'(IDX);
	assign last    = count == CW'(IDX + 1);
	assign match   = occ && (value_q == ctl.value);
	assign hit_out = hit_in | match;

	always_ff @(posedge clk) begin
		if (ctl.enq && count == CW'(IDX)) begin
			value_q <= ctl.value;
		end else if (ctl.deq) begin
			value_q <= right_value;
		end else if (ctl.rem && hit_out) begin
			// close up behind the first matching entry
			value_q <= right_value;
		end
	end

	assign value    = value_q;
	assign rear_tap = value_q & {32{last}};

endmodule

>>> rtl/fifo_queue_with_remove_by_value.sv
// FIFO queue of signed 32-bit words with remove-by-value.
// Request channel req (req_valid/req_ready) carries one operation: enqueue,
// dequeue, remove first matching word, clear, or peek (codes 5 to 7 peek).
// Response channel rsp (rsp_valid/rsp_ready) returns one word per request:
// status, dequeued word, front, rear, occupancy and empty flag after the op.
// Storage is a row of DEPTH cells; all cells compare and shift in parallel,
// so every operation completes in the cycle it is accepted.
// Response path: a stage holding the status after acceptance, then the
// response register, which reads front and rear off the row.
// Throughput: one request per cycle while rsp_ready is high; the rate is set
// by the parallel update of the cell row and the rear select over it.
// When the receiver stalls, the response register and the status stage fill
// and req_ready drops; nothing is lost or repeated.
// Reset (arst_n low) empties the queue and drops both pending stages; cell
// contents are not cleared, only the count.
// Depends on fqrv_pkg, fqrv_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "fifo_queue_with_remove_by_value_assert.svh"
module fifo_queue_with_remove_by_value
	import fqrv_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic          accept;
	logic          full;
	logic          empty;
	logic          hit;
	cell_ctl_t     ctl;

	logic [31:0] cell_val [DEPTH];
	logic [31:0] rear_tap [DEPTH];
	logic [DEPTH:0] hit_chain;

	logic          v_s1;
	status_t       status_s1;
	logic [31:0]   removed_s1;
	logic          adv;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	status_t       status_nx;
	logic [31:0]   rear_sel;

	assign full   = count_q == CW'(DEPTH);
	assign empty  = count_q == '0;
	assign adv    = v_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !v_s1 || adv;
	assign accept = req_valid && req_ready;

	always_comb begin
		ctl.enq   = accept && (req.kind == OP_ENQ) && !full;
		ctl.deq   = accept && (req.kind == OP_DEQ) && !empty;
		ctl.rem   = accept && (req.kind == OP_REMOVE);
		ctl.value = req.value;
	end

	assign hit_chain[0] = 1'b0;
	assign hit = hit_chain[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [31:0] right;
		if (i == DEPTH - 1) begin : g_end
			assign right = cell_val[i];
		end else begin : g_mid
			assign right = cell_val[i + 1];
		end
		fqrv_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.count       (count_q),
			.right_value (right),
			.hit_in      (hit_chain[i]),
			.hit_out     (hit_chain[i + 1]),
			.value       (cell_val[i]),
			.rear_tap    (rear_tap[i])
		);
	end

	always_comb begin
		status_nx = ST_OK;
		case (op_t'(req.kind))
			OP_ENQ:    status_nx = full ? ST_FULL : ST_OK;
			OP_DEQ:    status_nx = empty ? ST_MISS : ST_OK;
			OP_REMOVE: status_nx = hit ? ST_OK : ST_MISS;
			OP_CLEAR:  status_nx = ST_OK;
			default:   status_nx = empty ? ST_MISS : ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (req.kind == OP_CLEAR) begin
				count_q <= '0;
			end else if (ctl.enq) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.deq || (ctl.rem && hit)) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// status stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_nx;
			removed_s1 <= ctl.deq ? cell_val[0] : '0;
		end
	end

	// select the newest entry: at most one cell flags itself as last, none when empty
	always_comb begin
		rear_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_sel = rear_sel | rear_tap[i];
		end
	end

	// response register reads the row as left by the op in the status stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.status        <= status_s1;
			rsp_q.removed_value <= removed_s1;
			rsp_q.front_value   <= empty ? '0 : cell_val[0];
			rsp_q.rear_value    <= rear_sel;
			rsp_q.occupancy     <= 5'(count_q);
			rsp_q.is_empty      <= empty;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`FQRV_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH))
	`FQRV_ASSERT_NEXT(a_full_refused, accept && req.kind == OP_ENQ && full, status_s1 == ST_FULL && full)
	`FQRV_ASSERT_NEXT(a_clear_empties, accept && req.kind == OP_CLEAR, empty)
	`FQRV_ASSERT_SAME(a_empty_zero, rsp_valid_q && rsp_q.is_empty, rsp_q.front_value == '0 && rsp_q.rear_value == '0)

endmodule

>>> tb/fifo_queue_with_remove_by_value_tb.sv
// Testbench for fifo_queue_with_remove_by_value: directed and random operation streams,
// checked word by word against a behavioural queue model held in the bench.
// Depends on fqrv_pkg and the fifo_queue_with_remove_by_value RTL.
`timescale 1ns / 1ps
module fifo_queue_with_remove_by_value_tb;
	import fqrv_pkg::*;

	localparam int STORE_DEPTH = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_WORDS = 1720;
	localparam int DRAIN_CYCLES = 8;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
	// Codes above the last operation behave as peek
	localparam logic [2:0] OP_SPARE_5 = 3'd5;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef enum int {RSP_ALWAYS, RSP_RANDOM, RSP_BURSTY} rsp_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	logic signed [31:0] queue_model[$];
	rsp_t expected_rsp_q[$];
	rsp_t outcome;
	rsp_t want;
	int mismatch_count = 0;
	int cycle_count = 0;

	rsp_mode_t rsp_mode = RSP_ALWAYS;
	logic rsp_hold = 1'b0;
	int rsp_run = 0;
	logic gaps_on = 1'b0;
	int burst_left = 0;

	fifo_queue_with_remove_by_value #(
		.DEPTH(STORE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Apply one operation to the queue model and return the word it should produce
	function automatic rsp_t queue_apply(req_t op);
		rsp_t r;
		int hit;
		r = '0;
		r.status = ST_OK;
		hit = -1;
		case (op.kind)
			OP_ENQ: begin
				if (queue_model.size() >= STORE_DEPTH)
					r.status = ST_FULL;
				else
					queue_model.push_back(op.value);
			end
			OP_DEQ: begin
				if (queue_model.size() == 0)
					r.status = ST_MISS;
				else
					r.removed_value = queue_model.pop_front();
			end
			OP_REMOVE: begin
				foreach (queue_model[i])
					if (hit < 0 && queue_model[i] == op.value)
						hit = i;
				if (hit < 0)
					r.status = ST_MISS;
				else
					queue_model.delete(hit);
			end
			OP_CLEAR: begin
				queue_model.delete();
			end
			default: begin
				if (queue_model.size() == 0)
					r.status = ST_MISS;
			end
		endcase
		r.occupancy = 5'(queue_model.size());
		r.is_empty = (queue_model.size() == 0);
		if (queue_model.size() != 0) begin
			r.front_value = queue_model[0];
			r.rear_value = queue_model[$];
		end
		return r;
	endfunction

	function automatic void compare_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp, act);
			mismatch_count++;
		end
	endfunction

	// Predict on every accepted request word
	always @(posedge clk) begin
		if (arst_n && req_valid && req_ready) begin
			outcome = queue_apply(req);
			expected_rsp_q.push_back(outcome);
		end
	end

	// Check every accepted response word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				$display("%0t: response with none expected: expected none actual %p", $time, rsp);
				mismatch_count++;
			end else begin
				want = expected_rsp_q.pop_front();
				compare_field("status", 32'(want.status), 32'(rsp.status));
				compare_field("removed_value", want.removed_value, rsp.removed_value);
				compare_field("front_value", want.front_value, rsp.front_value);
				compare_field("rear_value", want.rear_value, rsp.rear_value);
				compare_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
				compare_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
			end
		end
	end

	// Receiver back-pressure pattern
	always @(posedge clk) begin
		case (rsp_mode)
			RSP_ALWAYS: begin
				rsp_ready <= 1'b1;
			end
			RSP_RANDOM: begin
				rsp_ready <= ($urandom_range(3) != 0);
			end
			default: begin
				if (rsp_run == 0) begin
					rsp_hold = ~rsp_hold;
					rsp_run = rsp_hold ? $urandom_range(1, 12) : $urandom_range(1, 8);
				end else begin
					rsp_run--;
				end
				rsp_ready <= ~rsp_hold;
			end
		endcase
	end

	// Hold one request word on the channel until it is taken
	task automatic send_word(input logic [2:0] kind, input logic signed [31:0] value);
		if (gaps_on && burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		if (burst_left > 0)
			burst_left--;
		req_valid <= 1'b1;
		req <= {kind, value};
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	task automatic test_empty_queue();
		rsp_mode = RSP_ALWAYS;
		gaps_on = 1'b0;
		send_word(OP_PEEK, 32'sd0);
		send_word(OP_DEQ, 32'sd0);
		send_word(OP_REMOVE, 32'sd0);
		send_word(OP_CLEAR, VAL_MAX);
	endtask

	task automatic test_fill_and_full();
		rsp_mode = RSP_RANDOM;
		send_word(OP_ENQ, VAL_MIN);
		send_word(OP_ENQ, VAL_MAX);
		send_word(OP_ENQ, 32'sd0);
		send_word(OP_ENQ, -32'sd1);
		for (int i = 0; i < STORE_DEPTH - 4; i++)
			send_word(OP_ENQ, (i % 3 == 0) ? -32'sd1 : $urandom);
		send_word(OP_ENQ, 32'sd5);
	endtask

	task automatic test_remove_by_value();
		rsp_mode = RSP_BURSTY;
		gaps_on = 1'b1;
		// first of several equal entries goes, the rest close up
		send_word(OP_REMOVE, -32'sd1);
		send_word(OP_REMOVE, 32'sd12345);
		send_word(OP_REMOVE, VAL_MIN);
		send_word(OP_DEQ, 32'sd0);
	endtask

	task automatic test_peek_codes();
		send_word(OP_SPARE_5, 32'sd0);
		send_word(OP_SPARE_6, VAL_MAX);
		send_word(OP_SPARE_7, VAL_MIN);
	endtask

	task automatic test_clear();
		send_word(OP_CLEAR, 32'sd0);
		send_word(OP_ENQ, 32'sd7);
		send_word(OP_REMOVE, 32'sd7);
	endtask

	task automatic test_random_traffic(input int n_words);
		int sent;
		int profile;
		int pick;
		int enq_pct;
		int deq_pct;
		logic [2:0] kind;
		logic signed [31:0] value;
		logic signed [31:0] pool[8];
		sent = 0;
		while (sent < n_words) begin
			profile = $urandom_range(2);
			rsp_mode = rsp_mode_t'($urandom_range(2));
			gaps_on = ($urandom_range(3) != 0);
			foreach (pool[i])
				pool[i] = $urandom;
			pool[0] = $urandom_range(1) ? VAL_MIN : VAL_MAX;
			case (profile)
				0: begin
					enq_pct = 60;
					deq_pct = 10;
				end
				1: begin
					enq_pct = 25;
					deq_pct = 35;
				end
				default: begin
					enq_pct = 40;
					deq_pct = 25;
				end
			endcase
			// Draw most values from a small pool so removes hit and entries repeat
			repeat ($urandom_range(40, 160)) begin
				pick = $urandom_range(99);
				if (pick < enq_pct)
					kind = OP_ENQ;
				else if (pick < enq_pct + deq_pct)
					kind = OP_DEQ;
				else if (pick < enq_pct + deq_pct + 22)
					kind = OP_REMOVE;
				else if (pick < enq_pct + deq_pct + 24)
					kind = OP_CLEAR;
				else if (pick < enq_pct + deq_pct + 27) begin
					case ($urandom_range(2))
						0: kind = OP_SPARE_5;
						1: kind = OP_SPARE_6;
						default: kind = OP_SPARE_7;
					endcase
				end else
					kind = OP_PEEK;
				if ($urandom_range(9) < 8)
					value = pool[$urandom_range(7)];
				else
					value = $urandom;
				send_word(kind, value);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_queue();
		test_fill_and_full();
		test_remove_by_value();
		test_peek_codes();
		test_clear();
		test_random_traffic(RANDOM_WORDS);
		req_valid <= 1'b0;
		// let the prediction for the last word land before looking at the queue
		@(posedge clk);
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
